>>> src/dars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk arm scheduler package
// Shared widths, register indexes, state codes, control structs and helpers.
// ----------------------------------------------------------------------------
package dars_pkg;

    localparam int TRACK_W         = 9;
    localparam int MOVE_W          = 15;
    localparam int CFG_IDX_W       = 2;
    localparam int KEY_W           = TRACK_W + 1;
    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int MAX_TRACK_DEF   = 500;

    localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TRACK = 2'd3;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic               start;
        logic               scan_mode;
        logic               sweep_down;
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] pivot;
    } sel_cmd_t;

    typedef struct packed {
        logic               done;
        logic [TRACK_W-1:0] best_track;
    } sel_stat_t;

    function automatic logic [TRACK_W-1:0] track_dist(
        input logic [TRACK_W-1:0] a,
        input logic [TRACK_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [TRACK_W-1:0] clamp_track(
        input logic [TRACK_W-1:0] v,
        input logic [TRACK_W-1:0] max_track
    );
        return (v > max_track) ? max_track : v;
    endfunction

endpackage

>>> src/dars_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one track request item and its end-of-batch flag.
// ----------------------------------------------------------------------------
interface dars_req_if;
    import dars_pkg::*;

    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] request_track;
    logic               batch_end;

    modport source (output valid, output request_track, output batch_end, input ready);
    modport sink (input valid, input request_track, input batch_end, output ready);

endinterface

>>> src/dars_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries one served track item with the running head movement.
// ----------------------------------------------------------------------------
interface dars_rsp_if;
    import dars_pkg::*;

    logic               valid;
    logic               ready;
    logic [TRACK_W-1:0] served_track;
    logic [MOVE_W-1:0]  total_movement;
    logic               last_served;

    modport source (output valid, output served_track, output total_movement,
                    output last_served, input ready);
    modport sink (input valid, input served_track, input total_movement,
                  input last_served, output ready);

endinterface

>>> src/dars_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface dars_cfg_if;
    import dars_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TRACK_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

>>> src/dars_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dars_store #(
    parameter int DEPTH = dars_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [IDX_W-1:0]             wr_addr,
    input  logic [dars_pkg::TRACK_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [IDX_W-1:0]             rd_addr,
    output logic [dars_pkg::TRACK_W-1:0] rd_data
);
    import dars_pkg::*;

    logic [TRACK_W-1:0] mem [DEPTH];
    logic [TRACK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/dars_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next-request selector
// Walks the queued requests through the memory read port and keeps the
// pending one with the smallest ordering key.
// ----------------------------------------------------------------------------
module dars_select #(
    parameter int DEPTH = dars_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dars_pkg::sel_cmd_t           cmd,
    input  logic [CNT_W-1:0]             count,
    input  logic [DEPTH-1:0]             served,
    output logic                         rd_en,
    output logic [IDX_W-1:0]             rd_addr,
    input  logic [dars_pkg::TRACK_W-1:0] rd_data,
    output dars_pkg::sel_stat_t          stat,
    output logic [IDX_W-1:0]             best_idx
);
    import dars_pkg::*;

    logic               issuing_reg;
    logic               chk_reg;
    logic               done_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic [KEY_W-1:0]   best_key_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [TRACK_W-1:0] best_trk_reg;

    logic [IDX_W-1:0]   last_idx;
    logic               in_front;
    logic               far_side;
    logic [TRACK_W-1:0] key_mag;
    logic [KEY_W-1:0]   key;
    logic               better;

    assign last_idx = IDX_W'(count - CNT_W'(1));

    // In LOOK mode the key ranks requests on the first leg of a sweep ahead of the
    // rest, and within a leg in the order the head meets them; else it is the seek distance.
    always_comb
    begin
        in_front = 1'b0;
        far_side = 1'b0;
        key_mag  = '0;
        if (!cmd.scan_mode)
        begin
            key_mag = track_dist(cmd.head, rd_data);
        end
        else if (!cmd.sweep_down)
        begin
            in_front = (rd_data >= cmd.pivot);
            far_side = !in_front;
            key_mag  = in_front ? rd_data : ~rd_data;
        end
        else
        begin
            in_front = (rd_data <= cmd.pivot);
            far_side = !in_front;
            key_mag  = in_front ? ~rd_data : rd_data;
        end
        key    = {far_side, key_mag};
        better = !served[chk_idx_reg] && (!found_reg || (key < best_key_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            chk_reg     <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            addr_reg    <= '0;
            chk_idx_reg <= '0;
        end
        else if (cmd.start)
        begin
            issuing_reg <= 1'b1;
            chk_reg     <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            addr_reg    <= '0;
        end
        else
        begin
            if (issuing_reg)
            begin
                addr_reg    <= addr_reg + IDX_W'(1);
                issuing_reg <= (addr_reg != last_idx);
            end
            chk_reg     <= issuing_reg;
            chk_idx_reg <= addr_reg;
            if (chk_reg && better)
            begin
                found_reg <= 1'b1;
            end
            if (chk_reg && (chk_idx_reg == last_idx))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk_reg && better)
        begin
            best_key_reg <= key;
            best_idx_reg <= chk_idx_reg;
            best_trk_reg <= rd_data;
        end
    end

    assign rd_en           = issuing_reg;
    assign rd_addr         = addr_reg;
    assign stat.done       = done_reg;
    assign stat.best_track = best_trk_reg;
    assign best_idx        = best_idx_reg;

endmodule

>>> src/disk_arm_request_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk arm request scheduler
// Queues a batch of track requests, then emits them in shortest-seek-first
// or LOOK sweep order with the running head movement.
// Loading accepts one request item per cycle while no batch is being
// scheduled; a request item without the batch end flag gives no result.
// Each served track needs one full pass over the request memory's single
// read port to select it, and the first result follows the selection pass
// that the batch end item starts.
// Reset sets the configuration to defaults and clears the queue count and
// served flags; the request memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module disk_arm_request_scheduler #(
    parameter int QUEUE_DEPTH = dars_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_TRACK   = dars_pkg::MAX_TRACK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dars_req_if.sink    req,
    dars_rsp_if.source  rsp,
    dars_cfg_if.sink    cfg
);
    import dars_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [TRACK_W-1:0] MAX_T = TRACK_W'(MAX_TRACK);

    state_t state_reg;
    state_t state_next;

    logic               scan_mode_reg;
    logic               sweep_down_reg;
    logic               start_first_reg;
    logic [TRACK_W-1:0] start_track_reg;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       served_cnt_reg;
    logic [QUEUE_DEPTH-1:0] served_reg;
    logic [TRACK_W-1:0]     first_reg;
    logic [TRACK_W-1:0]     head_reg;
    logic [TRACK_W-1:0]     pivot_reg;
    logic [MOVE_W-1:0]      sum_reg;

    logic               rsp_valid_reg;
    logic [TRACK_W-1:0] rsp_track_reg;
    logic [MOVE_W-1:0]  rsp_move_reg;
    logic               rsp_last_reg;

    logic               req_ready;
    logic               req_fire;
    logic               batch_go;
    logic               emit_fire;
    logic               sel_start;
    logic [TRACK_W-1:0] req_trk;
    logic               queue_full;
    logic               wr_en;
    logic [CNT_W-1:0]   count_after;
    logic [TRACK_W-1:0] start_head;
    logic               out_free;
    logic               is_last;
    logic [TRACK_W-1:0] step;
    logic [MOVE_W:0]    sum_wide;
    logic [MOVE_W-1:0]  sum_new;

    sel_cmd_t           sel_cmd;
    sel_stat_t          sel_stat;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [TRACK_W-1:0] rd_data;
    logic [IDX_W-1:0]   best_idx;

    assign req_trk     = clamp_track(req.request_track, MAX_T);
    assign req_fire    = req.valid && req_ready;
    assign batch_go    = req_fire && req.batch_end;
    assign queue_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign wr_en       = req_fire && !queue_full;
    assign count_after = queue_full ? count_reg : count_reg + CNT_W'(1);
    assign start_head  = !start_first_reg ? clamp_track(start_track_reg, MAX_T)
                       : (count_reg == '0) ? req_trk : first_reg;
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign is_last     = (served_cnt_reg == count_reg - CNT_W'(1));
    assign step        = track_dist(head_reg, sel_stat.best_track);
    assign sum_wide    = {1'b0, sum_reg} + (MOVE_W + 1)'(step);
    assign sum_new     = (sum_wide > (MOVE_W + 1)'(MOVE_MAX)) ? MOVE_MAX
                                                              : sum_wide[MOVE_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (batch_go)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (sel_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_LOAD : ST_SEARCH;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        emit_fire = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                req_ready = 1'b1;
            end
            ST_SEARCH:
            begin
                req_ready = 1'b0;
            end
            ST_EMIT:
            begin
                emit_fire = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        sel_start = batch_go || (emit_fire && !is_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            scan_mode_reg   <= 1'b0;
            sweep_down_reg  <= 1'b0;
            start_first_reg <= 1'b1;
            start_track_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_SCAN_MODE:   scan_mode_reg   <= cfg.data[0];
                    CFG_SWEEP_DOWN:  sweep_down_reg  <= cfg.data[0];
                    CFG_START_FIRST: start_first_reg <= cfg.data[0];
                    CFG_START_TRACK: start_track_reg <= cfg.data;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            served_cnt_reg <= '0;
            served_reg     <= '0;
            head_reg       <= '0;
            pivot_reg      <= '0;
            sum_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                count_reg <= count_after;
            end
            if (batch_go)
            begin
                head_reg       <= start_head;
                pivot_reg      <= start_head;
                sum_reg        <= '0;
                served_cnt_reg <= '0;
            end
            if (emit_fire)
            begin
                head_reg       <= sel_stat.best_track;
                served_cnt_reg <= served_cnt_reg + CNT_W'(1);
                if (is_last)
                begin
                    count_reg  <= '0;
                    served_reg <= '0;
                    sum_reg    <= '0;
                end
                else
                begin
                    served_reg[best_idx] <= 1'b1;
                    sum_reg              <= sum_new;
                end
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (count_reg == '0))
        begin
            first_reg <= req_trk;
        end
        if (emit_fire)
        begin
            rsp_track_reg <= sel_stat.best_track;
            rsp_move_reg  <= sum_new;
            rsp_last_reg  <= is_last;
        end
    end

    assign sel_cmd.start      = sel_start;
    assign sel_cmd.scan_mode  = scan_mode_reg;
    assign sel_cmd.sweep_down = sweep_down_reg;
    assign sel_cmd.head       = head_reg;
    assign sel_cmd.pivot      = pivot_reg;

    dars_store #(
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (req_trk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dars_select #(
        .DEPTH (QUEUE_DEPTH)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (sel_cmd),
        .count    (count_reg),
        .served   (served_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .stat     (sel_stat),
        .best_idx (best_idx)
    );

    assign req.ready          = req_ready;
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.served_track   = rsp_track_reg;
    assign rsp.total_movement = rsp_move_reg;
    assign rsp.last_served    = rsp_last_reg;

    a_emit_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> sel_stat.done)
        else $error("Result emitted before the selection pass finished.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Request count exceeds the queue depth.");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> ((count_reg == '0) && (served_reg == '0)))
        else $error("Batch state not cleared after the final result.");

    a_served_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (served_cnt_reg < count_reg))
        else $error("Served count reached the batch size while scheduling.");

endmodule

>>> sim/tb_disk_arm_request_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk arm request scheduler testbench
// Sends batches of track requests through the request channel and checks
// every served track, running movement and last flag against a schedule
// worked out in the bench for both shortest-seek-first and LOOK ordering.
// A short table of directed items comes first, followed by random batches
// under several register settings and sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_disk_arm_request_scheduler;
    import dars_pkg::*;

    localparam int QDEPTH        = QUEUE_DEPTH_DEF;
    localparam int TRACK_LIMIT   = MAX_TRACK_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 55;
    localparam int PRINT_LIMIT   = 30;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [TRACK_W-1:0]   val;
        logic                 fin;
        logic                 typed;
        logic [TRACK_W-1:0]   exp_track;
        logic [MOVE_W-1:0]    exp_moved;
    } row_t;

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [MOVE_W-1:0]  moved;
        logic               fin;
    } service_t;

    localparam int DIR_ROWS = 33;
    localparam row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM, '0, 9'd0,   1'b1, 1'b1, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd511, 1'b1, 1'b1, 9'd500, 15'd0},
        '{ROW_ITEM, '0, 9'd500, 1'b1, 1'b1, 9'd500, 15'd0},
        '{ROW_ITEM, '0, 9'd100, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd90,  1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd110, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd300, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd0,   1'b1, 1'b0, 9'd0,   15'd0},
        '{ROW_CFG,  CFG_START_FIRST, 9'd0,   1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_CFG,  CFG_START_TRACK, 9'd250, 1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd260, 1'b1, 1'b1, 9'd260, 15'd10},
        '{ROW_CFG,  CFG_SCAN_MODE,   9'd1,   1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_CFG,  CFG_START_TRACK, 9'd400, 1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd100, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd200, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd300, 1'b1, 1'b0, 9'd0,   15'd0},
        '{ROW_CFG,  CFG_SWEEP_DOWN,  9'd1,   1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_CFG,  CFG_START_TRACK, 9'd50,  1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd300, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd100, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd200, 1'b1, 1'b0, 9'd0,   15'd0},
        '{ROW_CFG,  CFG_START_TRACK, 9'd200, 1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd250, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd200, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd150, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd511, 1'b1, 1'b0, 9'd0,   15'd0},
        '{ROW_CFG,  CFG_SWEEP_DOWN,  9'd0,   1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd250, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd200, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd150, 1'b0, 1'b0, 9'd0,   15'd0},
        '{ROW_ITEM, '0, 9'd0,   1'b1, 1'b0, 9'd0,   15'd0},
        '{ROW_CFG,  CFG_START_TRACK, 9'd511, 1'b0, 1'b0, 9'd0, 15'd0},
        '{ROW_ITEM, '0, 9'd500, 1'b1, 1'b1, 9'd500, 15'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    dars_req_if req_ch();
    dars_rsp_if rsp_ch();
    dars_cfg_if cfg_ch();

    disk_arm_request_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Register shadows and pending batch held by the scheduling predictor.
    logic               mode_scan;
    logic               mode_down;
    logic               mode_first;
    logic [TRACK_W-1:0] mode_start;
    int                 pend_tracks [QDEPTH];
    int                 pend_count;

    service_t batch_plan [$];
    service_t due_services [$];

    int idle_mode;
    int cycle_count;
    int mismatches;
    int items_sent;
    int batches_done;
    int scan_batches;
    int overfull_batches;
    int results_checked;
    int reg_writes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int track_gap(input int a, input int b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic int limit_track(input int v);
        return (v > TRACK_LIMIT) ? TRACK_LIMIT : v;
    endfunction

    function automatic logic sender_idles();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_SEND && roll < 61) || (idle_mode == IDLE_BOTH && roll < 29);
    endfunction

    function automatic logic receiver_stalls();
        int roll;
        roll = $urandom_range(99);
        return (idle_mode == IDLE_RECV && roll < 61) || (idle_mode == IDLE_BOTH && roll < 29);
    endfunction

    task automatic report_mismatch(input string what);
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("MISMATCH @%0t: %s", $time, what);
        end
    endtask

    // Works out the service order of the pending batch into batch_plan.
    task automatic plan_schedule();
        int order [$];
        int sorted [QDEPTH];
        bit done_flag [QDEPTH];
        int n;
        int arm;
        int best;
        int bestd;
        int pivot;
        int v;
        int j;
        int moved;
        service_t svc;
        begin
            n = pend_count;
            arm = mode_first ? pend_tracks[0] : limit_track(mode_start);
            if (!mode_scan) begin
                for (int i = 0; i < n; i++)
                    done_flag[i] = 1'b0;
                for (int k = 0; k < n; k++) begin
                    best = -1;
                    bestd = 0;
                    for (int i = 0; i < n; i++) begin
                        if (!done_flag[i] &&
                            (best < 0 || track_gap(arm, pend_tracks[i]) < bestd)) begin
                            best = i;
                            bestd = track_gap(arm, pend_tracks[i]);
                        end
                    end
                    done_flag[best] = 1'b1;
                    order = {order, pend_tracks[best]};
                    arm = pend_tracks[best];
                end
                arm = mode_first ? pend_tracks[0] : limit_track(mode_start);
            end else begin
                scan_batches++;
                for (int i = 0; i < n; i++) begin
                    v = pend_tracks[i];
                    j = i;
                    while (j > 0 && sorted[j - 1] > v) begin
                        sorted[j] = sorted[j - 1];
                        j--;
                    end
                    sorted[j] = v;
                end
                pivot = -1;
                if (!mode_down) begin
                    for (int i = 0; i < n; i++) begin
                        if (sorted[i] >= arm) begin
                            pivot = i;
                            break;
                        end
                    end
                    if (pivot < 0) begin
                        for (int i = n - 1; i >= 0; i--)
                            order = {order, sorted[i]};
                    end else begin
                        for (int i = pivot; i < n; i++)
                            order = {order, sorted[i]};
                        for (int i = pivot - 1; i >= 0; i--)
                            order = {order, sorted[i]};
                    end
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (sorted[i] <= arm)
                            pivot = i;
                        else
                            break;
                    end
                    for (int i = pivot; i >= 0; i--)
                        order = {order, sorted[i]};
                    for (int i = pivot + 1; i < n; i++)
                        order = {order, sorted[i]};
                end
            end
            moved = 0;
            foreach (order[i]) begin
                moved = moved + track_gap(arm, order[i]);
                if (moved > int'(MOVE_MAX))
                    moved = int'(MOVE_MAX);
                arm = order[i];
                svc.track = TRACK_W'(order[i]);
                svc.moved = MOVE_W'(moved);
                svc.fin = (i == order.size() - 1);
                batch_plan = {batch_plan, svc};
            end
            batches_done++;
        end
    endtask

    task automatic take_request(input logic [TRACK_W-1:0] raw, input logic fin);
        begin
            batch_plan.delete();
            if (pend_count < QDEPTH) begin
                pend_tracks[pend_count] = limit_track(raw);
                pend_count++;
            end else if (fin) begin
                overfull_batches++;
            end
            if (fin && pend_count > 0) begin
                plan_schedule();
                pend_count = 0;
            end
        end
    endtask

    task automatic send_request(
        input logic [TRACK_W-1:0] trk,
        input logic               fin,
        input logic               typed,
        input logic [TRACK_W-1:0] exp_track,
        input logic [MOVE_W-1:0]  exp_moved
    );
        service_t svc;
        begin
            while (sender_idles()) begin
                req_ch.valid = 1'b0;
                @(negedge clk);
            end
            req_ch.valid = 1'b1;
            req_ch.request_track = trk;
            req_ch.batch_end = fin;
            @(posedge clk);
            while (!req_ch.ready)
                @(posedge clk);
            take_request(trk, fin);
            if (typed && fin) begin
                svc.track = exp_track;
                svc.moved = exp_moved;
                svc.fin = 1'b1;
                due_services = {due_services, svc};
            end else begin
                foreach (batch_plan[i])
                    due_services = {due_services, batch_plan[i]};
            end
            items_sent++;
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TRACK_W-1:0] val);
        begin
            while (due_services.size() != 0)
                @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            cfg_ch.valid = 1'b1;
            cfg_ch.index = idx;
            cfg_ch.data = val;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            case (idx)
                CFG_SCAN_MODE:   mode_scan = val[0];
                CFG_SWEEP_DOWN:  mode_down = val[0];
                CFG_START_FIRST: mode_first = val[0];
                CFG_START_TRACK: mode_start = val;
                default: ;
            endcase
            reg_writes++;
            @(negedge clk);
            cfg_ch.valid = 1'b0;
        end
    endtask

    function automatic logic [TRACK_W-1:0] pick_start();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return TRACK_W'(TRACK_LIMIT);
        return TRACK_W'($urandom_range(TRACK_LIMIT));
    endfunction

    function automatic logic [TRACK_W-1:0] pick_track(input logic [TRACK_W-1:0] prev);
        int roll;
        roll = $urandom_range(99);
        if (roll < 75)
            return TRACK_W'($urandom_range(511));
        if (roll < 87)
            return prev;
        case ($urandom_range(3))
            0: return 9'd0;
            1: return 9'd500;
            2: return 9'd501;
            default: return 9'd511;
        endcase
    endfunction

    task automatic write_random_reg();
        logic [CFG_IDX_W-1:0] idx;
        begin
            idx = CFG_IDX_W'($urandom_range(3));
            if (idx == CFG_START_TRACK)
                write_reg(idx, pick_start());
            else
                write_reg(idx, TRACK_W'($urandom_range(1)));
        end
    endtask

    task automatic send_batch(output int count);
        int roll;
        logic [TRACK_W-1:0] trk;
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                count = $urandom_range(6, 1);
            else if (roll < 88)
                count = $urandom_range(16, 7);
            else if (roll < 96)
                count = $urandom_range(QDEPTH, 17);
            else
                count = $urandom_range(QDEPTH + 4, QDEPTH + 1);
            trk = TRACK_W'($urandom_range(511));
            for (int i = 0; i < count; i++) begin
                trk = pick_track(trk);
                send_request(trk, i == count - 1, 1'b0, '0, '0);
            end
        end
    endtask

    always @(negedge clk)
        rsp_ch.ready = !receiver_stalls();

    always @(posedge clk)
    begin : result_check
        service_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (due_services.size() == 0) begin
                report_mismatch($sformatf("unexpected result track %0d movement %0d",
                                          rsp_ch.served_track, rsp_ch.total_movement));
            end else begin
                want = due_services.pop_front();
                results_checked++;
                if (rsp_ch.served_track !== want.track)
                    report_mismatch($sformatf("served_track %0d, expected %0d",
                                              rsp_ch.served_track, want.track));
                if (rsp_ch.total_movement !== want.moved)
                    report_mismatch($sformatf("total_movement %0d, expected %0d",
                                              rsp_ch.total_movement, want.moved));
                if (rsp_ch.last_served !== want.fin)
                    report_mismatch($sformatf("last_served %0b, expected %0b",
                                              rsp_ch.last_served, want.fin));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding.",
                     cycle_count, due_services.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int phase_items;
        int batch_items;
        row_t row;
        int phase_modes [4];

        phase_modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.request_track = '0;
        req_ch.batch_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_SCAN_MODE;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        mode_scan = 1'b0;
        mode_down = 1'b0;
        mode_first = 1'b1;
        mode_start = '0;
        pend_count = 0;
        idle_mode = IDLE_NONE;
        cycle_count = 0;
        mismatches = 0;
        items_sent = 0;
        batches_done = 0;
        scan_batches = 0;
        overfull_batches = 0;
        results_checked = 0;
        reg_writes = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.val);
            else
                send_request(row.val, row.fin, row.typed, row.exp_track, row.exp_moved);
        end

        foreach (phase_modes[p]) begin
            idle_mode = phase_modes[p];
            write_reg(CFG_SCAN_MODE, TRACK_W'($urandom_range(1)));
            write_reg(CFG_SWEEP_DOWN, TRACK_W'($urandom_range(1)));
            write_reg(CFG_START_FIRST, TRACK_W'($urandom_range(1)));
            if (p == 0)
                write_reg(CFG_START_TRACK, '0);
            else if (p == 1)
                write_reg(CFG_START_TRACK, TRACK_W'(TRACK_LIMIT));
            else
                write_reg(CFG_START_TRACK, pick_start());
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                if ($urandom_range(3) == 0)
                    write_random_reg();
                send_batch(batch_items);
                phase_items += batch_items;
            end
        end

        while (due_services.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d request items in %0d batches (%0d in scan order, %0d overfull).",
                 items_sent, batches_done, scan_batches, overfull_batches);
        $display("Checked %0d served tracks across %0d register writes and four idling patterns.",
                 results_checked, reg_writes);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> disk_arm_request_scheduler.f
src/dars_pkg.sv
src/dars_req_if.sv
src/dars_rsp_if.sv
src/dars_cfg_if.sv
src/dars_store.sv
src/dars_select.sv
src/disk_arm_request_scheduler.sv
sim/tb_disk_arm_request_scheduler.sv
